>>> rtl/tdssm_pkg.sv
// Shared constants, register codes and the glyph table of the two-digit display driver.
package tdssm_pkg;

    localparam int GLYPH_IDX_W = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_DISPLAY_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_PERIOD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOWN_NUMBER = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTENT_CODE = 2'd3;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_BLINK = 2'd1;
    localparam logic [1:0] MODE_ON    = 2'd2;

    localparam logic [1:0] CONTENT_NUMBER  = 2'd0;
    localparam logic [1:0] CONTENT_ERROR   = 2'd1;
    localparam logic [1:0] CONTENT_BATTERY = 2'd2;
    localparam logic [1:0] CONTENT_LOW     = 2'd3;

    localparam logic [15:0] BLINK_PERIOD_RESET = 16'd250;
    localparam logic [7:0]  NUMBER_MAX         = 8'd99;

    localparam logic [GLYPH_IDX_W-1:0] GLYPH_UPPER_A = 5'd10;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_LOWER_B = 5'd11;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_UPPER_E = 5'd14;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_UPPER_L = 5'd16;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_LOWER_O = 5'd17;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_LOWER_R = 5'd18;

    function automatic logic [6:0] glyph_pattern(input logic [GLYPH_IDX_W-1:0] idx);
        logic [6:0] pattern;
        case (idx)
            5'd0:    pattern = 7'h3F;
            5'd1:    pattern = 7'h06;
            5'd2:    pattern = 7'h5B;
            5'd3:    pattern = 7'h4F;
            5'd4:    pattern = 7'h66;
            5'd5:    pattern = 7'h6D;
            5'd6:    pattern = 7'h7D;
            5'd7:    pattern = 7'h07;
            5'd8:    pattern = 7'h7F;
            5'd9:    pattern = 7'h6F;
            5'd10:   pattern = 7'h77;
            5'd11:   pattern = 7'h7C;
            5'd12:   pattern = 7'h39;
            5'd13:   pattern = 7'h5E;
            5'd14:   pattern = 7'h79;
            5'd15:   pattern = 7'h71;
            5'd16:   pattern = 7'h38;
            5'd17:   pattern = 7'h5C;
            5'd18:   pattern = 7'h50;
            default: pattern = 7'h00;
        endcase
        return pattern;
    endfunction

endpackage

>>> rtl/two_digit_seven_segment_mux.sv
// Top level of the two-digit multiplexed seven-segment display driver.
// The drive of an accepted beat is written into the output registers, which hold it until it is taken.
// Throughput: one beat per cycle while the output is not stalled; the output register refills while its beat is taken.
// Reset clears digit select, blink counter, visibility flag and output valid.
// Reset also returns the registers to mode off, blink period 250, number 0 and content 0.
module two_digit_seven_segment_mux
    import tdssm_pkg::*;
#(
    parameter int GLYPH_COUNT = 19
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   tick,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [6:0]             segments_n,
    output logic                   left_on,
    output logic                   right_on,
    output logic                   right_selected
);

    logic [1:0]  display_mode_reg;
    logic [15:0] blink_period_reg;
    logic [7:0]  shown_number_reg;
    logic [1:0]  content_code_reg;

    logic        digit_sel_reg;
    logic        digit_sel_next;
    logic [15:0] blink_count_reg;
    logic [15:0] blink_count_next;
    logic        visible_reg;
    logic        visible_next;

    logic        out_valid_reg;
    logic [6:0]  segments_n_reg;
    logic        left_on_reg;
    logic        right_on_reg;
    logic        right_selected_reg;

    logic        in_accept;
    logic        lit;
    logic [6:0]  segments_n_next;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_mode_reg <= MODE_OFF;
            blink_period_reg <= BLINK_PERIOD_RESET;
            shown_number_reg <= 8'd0;
            content_code_reg <= CONTENT_NUMBER;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DISPLAY_MODE: display_mode_reg <= cfg_data[1:0];
                CFG_BLINK_PERIOD: blink_period_reg <= cfg_data;
                CFG_SHOWN_NUMBER: shown_number_reg <= cfg_data[7:0];
                CFG_CONTENT_CODE: content_code_reg <= cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        digit_sel_next   = digit_sel_reg;
        blink_count_next = blink_count_reg;
        visible_next     = visible_reg;
        if (tick)
        begin
            digit_sel_next = !digit_sel_reg;
            if (display_mode_reg == MODE_BLINK)
            begin
                if (blink_count_reg >= blink_period_reg)
                begin
                    visible_next     = !visible_reg;
                    blink_count_next = 16'd1;
                end
                else
                begin
                    blink_count_next = blink_count_reg + 16'd1;
                end
            end
        end
    end

    always_comb
    begin
        case (display_mode_reg)
            MODE_ON:    lit = 1'b1;
            MODE_BLINK: lit = visible_next;
            default:    lit = 1'b0;
        endcase
    end

    tdssm_glyph #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_glyph (
        .shown_number (shown_number_reg),
        .content_code (content_code_reg),
        .right_sel    (digit_sel_next),
        .segments_n   (segments_n_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_sel_reg   <= 1'b0;
            blink_count_reg <= 16'd0;
            visible_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                digit_sel_reg   <= digit_sel_next;
                blink_count_reg <= blink_count_next;
                visible_reg     <= visible_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            segments_n_reg     <= segments_n_next;
            left_on_reg        <= lit && !digit_sel_next;
            right_on_reg       <= lit && digit_sel_next;
            right_selected_reg <= digit_sel_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign segments_n     = segments_n_reg;
    assign left_on        = left_on_reg;
    assign right_on       = right_on_reg;
    assign right_selected = right_selected_reg;

`ifndef SYNTHESIS
    a_one_anode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(left_on_reg && right_on_reg))
        else $error("Both anodes are enabled at once.");

    a_anode_matches_select: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((!right_on_reg || right_selected_reg)
                           && (!left_on_reg || !right_selected_reg)))
        else $error("Enabled anode does not match the addressed digit.");

    a_tick_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && tick) |=> (digit_sel_reg != $past(digit_sel_reg)))
        else $error("An accepted tick did not toggle the digit select.");

    a_blink_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_accept && tick && (display_mode_reg == MODE_BLINK))
        |=> ($stable(blink_count_reg) && $stable(visible_reg)))
        else $error("Blink state changed without a tick in blinking mode.");

    a_select_reflects_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (right_selected_reg == digit_sel_reg))
        else $error("Output digit select differs from the held state.");
`endif

endmodule

>>> rtl/tdssm_glyph.sv
// Digit selection and glyph lookup that turn the shown content into segment lines.
module tdssm_glyph
    import tdssm_pkg::*;
#(
    parameter int GLYPH_COUNT = 19
)
(
    input  logic [7:0] shown_number,
    input  logic [1:0] content_code,
    input  logic       right_sel,
    output logic [6:0] segments_n
);

    localparam logic [GLYPH_IDX_W:0] GLYPH_LIMIT = (GLYPH_IDX_W + 1)'(GLYPH_COUNT);

    logic [7:0]             number_sat;
    logic [15:0]            tens_product;
    logic [3:0]             tens;
    logic [7:0]             tens_times_ten;
    logic [3:0]             units;
    logic [GLYPH_IDX_W-1:0] idx;
    logic [6:0]             pattern;

    assign number_sat     = (shown_number > NUMBER_MAX) ? NUMBER_MAX : shown_number;
    // Multiplying by 205 and dropping 11 bits divides by ten; the four-bit tens field holds it for values below 160.
    assign tens_product   = 16'(number_sat) * 16'd205;
    assign tens           = tens_product[14:11];
    assign tens_times_ten = 8'(tens) * 8'd10;
    assign units          = 4'(number_sat - tens_times_ten);

    always_comb
    begin
        case (content_code)
            CONTENT_ERROR:   idx = right_sel ? GLYPH_LOWER_R : GLYPH_UPPER_E;
            CONTENT_BATTERY: idx = right_sel ? GLYPH_UPPER_A : GLYPH_LOWER_B;
            CONTENT_LOW:     idx = right_sel ? GLYPH_LOWER_O : GLYPH_UPPER_L;
            default:         idx = right_sel ? GLYPH_IDX_W'(units) : GLYPH_IDX_W'(tens);
        endcase
    end

    assign pattern    = ({1'b0, idx} < GLYPH_LIMIT) ? glyph_pattern(idx) : 7'h00;
    assign segments_n = ~pattern;

endmodule
